// ===== rtl/core/cthc_pkg.sv =====
`default_nettype none

package cthc_pkg;

    // field widths
    localparam int RAW_W     = 16;
    localparam int CAL_W     = 7;
    localparam int OUT_W     = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // datapath widths
    localparam int DIFF_W  = RAW_W + 1;        // raw minus raw point
    localparam int DY_W    = CAL_W + 1;        // difference of two cal points
    localparam int DY10_W  = DY_W + 4;         // that difference times ten
    localparam int Y10_W   = CAL_W + 4;        // cal point times ten
    localparam int PROD_W  = DIFF_W + DY10_W;  // signed numerator
    localparam int DVD_W   = 27;               // numerator magnitude, below 2^27
    localparam int DVS_W   = RAW_W;            // denominator magnitude

    // pipeline shape: difference, multiply, magnitude, divider, sign fix
    localparam int DIV_STAGES = DVD_W;
    localparam int PIPE_DEPTH = 3 + DIV_STAGES + 1;

    localparam logic signed [OUT_W-1:0] HUM_CLAMP = OUT_W'(1000);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CAL_LOW  = 3'd0,
        REG_TEMP_CAL_HIGH = 3'd1,
        REG_TEMP_RAW_LOW  = 3'd2,
        REG_TEMP_RAW_HIGH = 3'd3,
        REG_HUM_CAL_LOW   = 3'd4,
        REG_HUM_CAL_HIGH  = 3'd5,
        REG_HUM_RAW_LOW   = 3'd6,
        REG_HUM_RAW_HIGH  = 3'd7
    } cthc_reg_t;

    // one divider stage of one channel
    typedef struct packed {
        logic [DVD_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
        logic [DVS_W-1:0] rem;
        logic [DVD_W-1:0] quo;
        logic             neg;
        logic             err;
        logic [Y10_W-1:0] y0_10;
    } cthc_div_t;

    // signed quotient of one channel, before offset and clamp
    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic [Y10_W-1:0] y0_10;
        logic             err;
    } cthc_res_t;

    // result payload
    typedef struct packed {
        logic [OUT_W-1:0] temperature_tenths;
        logic [OUT_W-1:0] humidity_tenths;
        logic             temp_cal_error;
        logic             hum_cal_error;
    } cthc_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/cthc_if.sv =====
`default_nettype none

// raw sample pair channel
interface cthc_in_if import cthc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_temperature;
    logic signed [RAW_W-1:0] raw_humidity;

    modport source (output valid, output raw_temperature, output raw_humidity, input ready);
    modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

// converted result channel
interface cthc_out_if import cthc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] temperature_tenths;
    logic signed [OUT_W-1:0] humidity_tenths;
    logic                    temp_cal_error;
    logic                    hum_cal_error;

    modport source (output valid, output temperature_tenths, output humidity_tenths,
                    output temp_cal_error, output hum_cal_error, input ready);
    modport sink   (input valid, input temperature_tenths, input humidity_tenths,
                    input temp_cal_error, input hum_cal_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cthc_chan.sv =====
`default_nettype none

module cthc_chan import cthc_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [RAW_W-1:0] raw,
    input  wire logic signed [RAW_W-1:0] x0,
    input  wire logic signed [RAW_W-1:0] x1,
    input  wire logic        [CAL_W-1:0] y0,
    input  wire logic        [CAL_W-1:0] y1,
    output cthc_res_t                    res
);

    logic signed [DIFF_W-1:0] a_dx_reg;
    logic signed [DIFF_W-1:0] a_den_reg;
    logic signed [DY10_W-1:0] a_dy10_reg;
    logic        [Y10_W-1:0]  a_y10_reg;
    logic signed [DIFF_W-1:0] a_dx_next;
    logic signed [DIFF_W-1:0] a_den_next;
    logic signed [DY_W-1:0]   a_dy;
    logic signed [DY10_W-1:0] a_dy10_next;
    logic        [Y10_W-1:0]  a_y10_next;

    logic signed [PROD_W-1:0] b_prod_reg;
    logic signed [DIFF_W-1:0] b_den_reg;
    logic        [Y10_W-1:0]  b_y10_reg;
    logic signed [PROD_W-1:0] b_prod_next;

    cthc_div_t                c_reg;
    cthc_div_t                c_next;
    logic signed [PROD_W-1:0] c_prod_abs;
    logic signed [DIFF_W-1:0] c_den_abs;

    cthc_div_t                div_in   [DIV_STAGES];
    cthc_div_t                div_next [DIV_STAGES];
    cthc_div_t                div_reg  [DIV_STAGES];
    logic [DVS_W:0]           trial    [DIV_STAGES];
    logic [DIV_STAGES-1:0]    ge;

    cthc_res_t                d_reg;
    cthc_res_t                d_next;
    cthc_div_t                d_in;

    // stage a: differences and the scaled slope terms
    always_comb
    begin
        a_dx_next   = DIFF_W'(raw) - DIFF_W'(x0);
        a_den_next  = DIFF_W'(x1) - DIFF_W'(x0);
        a_dy        = $signed({1'b0, y1}) - $signed({1'b0, y0});
        // times ten as eight plus two
        a_dy10_next = (DY10_W'(a_dy) <<< 3) + (DY10_W'(a_dy) <<< 1);
        a_y10_next  = (Y10_W'(y0) << 3) + (Y10_W'(y0) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg   <= a_dx_next;
            a_den_reg  <= a_den_next;
            a_dy10_reg <= a_dy10_next;
            a_y10_reg  <= a_y10_next;
        end
    end

    // stage b: numerator product
    assign b_prod_next = PROD_W'(a_dx_reg) * PROD_W'(a_dy10_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_prod_reg <= b_prod_next;
            b_den_reg  <= a_den_reg;
            b_y10_reg  <= a_y10_reg;
        end
    end

    // stage c: magnitudes and quotient sign for the divider
    always_comb
    begin
        c_prod_abs   = b_prod_reg[PROD_W-1] ? -b_prod_reg : b_prod_reg;
        c_den_abs    = b_den_reg[DIFF_W-1] ? -b_den_reg : b_den_reg;
        c_next.dvd   = c_prod_abs[DVD_W-1:0];
        c_next.dvs   = c_den_abs[DVS_W-1:0];
        c_next.rem   = '0;
        c_next.quo   = '0;
        c_next.neg   = b_prod_reg[PROD_W-1] ^ b_den_reg[DIFF_W-1];
        c_next.err   = (b_den_reg == '0);
        c_next.y0_10 = b_y10_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    always_comb
    begin
        div_in[0] = c_reg;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            div_in[k] = div_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            trial[k]        = {div_in[k].rem, div_in[k].dvd[DVD_W-1]};
            ge[k]           = (trial[k] >= {1'b0, div_in[k].dvs});
            div_next[k]     = div_in[k];
            div_next[k].dvd = {div_in[k].dvd[DVD_W-2:0], 1'b0};
            div_next[k].quo = {div_in[k].quo[DVD_W-2:0], ge[k]};
            div_next[k].rem = ge[k] ? DVS_W'(trial[k] - {1'b0, div_in[k].dvs})
                                    : trial[k][DVS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    // stage d: restore the sign of the truncated quotient
    always_comb
    begin
        d_in         = div_reg[DIV_STAGES-1];
        d_next.val   = d_in.neg ? -{1'b0, d_in.quo} : {1'b0, d_in.quo};
        d_next.y0_10 = d_in.y0_10;
        d_next.err   = d_in.err;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign res = d_reg;

endmodule

`default_nettype wire

// ===== rtl/core/calibrated_temp_humidity_convert_top.sv =====
// Two-point linear calibration of a temperature and humidity sample pair.
// sample channel: one request carries a raw temperature and a raw humidity
// sample; it is taken at a clock edge with valid and ready both high.
// result channel: one request per sample pair, in order, with both values in
// tenths of a unit and a calibration error flag per channel. Equal raw
// calibration points force that channel's value to 0 and set its flag.
// Humidity is clamped above at 1000.
// The cfg port writes one calibration register per cycle with cfg_we high;
// write it only while no sample pair is in flight.
// Throughput: one sample pair per cycle while the skid register is empty; the
// 27-stage restoring divider that yields one quotient bit per stage sets the
// depth, the 17x12 multiply sits in a stage of its own.
// When the receiver stalls, the output register holds and one more result
// lands in a skid register; sample.ready then drops and the whole pipeline
// freezes until the skid register empties, so nothing is lost or repeated.
// Reset clears all calibration registers to 0 and empties the pipeline.
`default_nettype none

module calibrated_temp_humidity_convert_top import cthc_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    cthc_in_if.sink                   sample,
    cthc_out_if.source                result
);

    logic        [CAL_W-1:0] temp_cal_low_reg;
    logic        [CAL_W-1:0] temp_cal_high_reg;
    logic signed [RAW_W-1:0] temp_raw_low_reg;
    logic signed [RAW_W-1:0] temp_raw_high_reg;
    logic        [CAL_W-1:0] hum_cal_low_reg;
    logic        [CAL_W-1:0] hum_cal_high_reg;
    logic signed [RAW_W-1:0] hum_raw_low_reg;
    logic signed [RAW_W-1:0] hum_raw_high_reg;

    logic                    en;
    logic [PIPE_DEPTH-1:0]   vld_reg;
    cthc_res_t               t_res;
    cthc_res_t               h_res;
    logic signed [OUT_W-1:0] t_sum;
    logic signed [OUT_W-1:0] h_sum;
    cthc_out_t               fin;
    logic                    fin_vld;

    cthc_out_t               out_reg;
    cthc_out_t               out_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    cthc_out_t               skid_reg;
    cthc_out_t               skid_next;
    logic                    skid_vld_reg;
    logic                    skid_vld_next;
    logic                    take;

    // calibration registers, extra high bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_low_reg  <= '0;
            temp_cal_high_reg <= '0;
            temp_raw_low_reg  <= '0;
            temp_raw_high_reg <= '0;
            hum_cal_low_reg   <= '0;
            hum_cal_high_reg  <= '0;
            hum_raw_low_reg   <= '0;
            hum_raw_high_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cthc_reg_t'(cfg_index))
                REG_TEMP_CAL_LOW:  temp_cal_low_reg  <= cfg_data[CAL_W-1:0];
                REG_TEMP_CAL_HIGH: temp_cal_high_reg <= cfg_data[CAL_W-1:0];
                REG_TEMP_RAW_LOW:  temp_raw_low_reg  <= cfg_data[RAW_W-1:0];
                REG_TEMP_RAW_HIGH: temp_raw_high_reg <= cfg_data[RAW_W-1:0];
                REG_HUM_CAL_LOW:   hum_cal_low_reg   <= cfg_data[CAL_W-1:0];
                REG_HUM_CAL_HIGH:  hum_cal_high_reg  <= cfg_data[CAL_W-1:0];
                REG_HUM_RAW_LOW:   hum_raw_low_reg   <= cfg_data[RAW_W-1:0];
                REG_HUM_RAW_HIGH:  hum_raw_high_reg  <= cfg_data[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid register is free
    assign en           = !skid_vld_reg;
    assign sample.ready = en;

    // valid bits riding along with the datapath stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], sample.valid};
        end
    end

    cthc_chan u_temp (
        .clk (clk),
        .en  (en),
        .raw (sample.raw_temperature),
        .x0  (temp_raw_low_reg),
        .x1  (temp_raw_high_reg),
        .y0  (temp_cal_low_reg),
        .y1  (temp_cal_high_reg),
        .res (t_res)
    );

    cthc_chan u_hum (
        .clk (clk),
        .en  (en),
        .raw (sample.raw_humidity),
        .x0  (hum_raw_low_reg),
        .x1  (hum_raw_high_reg),
        .y0  (hum_cal_low_reg),
        .y1  (hum_cal_high_reg),
        .res (h_res)
    );

    // offset, humidity clamp and error override
    always_comb
    begin
        t_sum = $signed(t_res.val + OUT_W'(t_res.y0_10));
        h_sum = $signed(h_res.val + OUT_W'(h_res.y0_10));
        fin.temperature_tenths = t_res.err ? '0 : t_sum;
        if (h_res.err)
        begin
            fin.humidity_tenths = '0;
        end
        else if (h_sum > HUM_CLAMP)
        begin
            fin.humidity_tenths = HUM_CLAMP;
        end
        else
        begin
            fin.humidity_tenths = h_sum;
        end
        fin.temp_cal_error = t_res.err;
        fin.hum_cal_error  = h_res.err;
        fin_vld            = en && vld_reg[PIPE_DEPTH-1];
    end

    // output register with skid register behind it
    always_comb
    begin
        take          = !out_vld_reg || result.ready;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (take)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_next     = fin;
                out_vld_next = fin_vld;
            end
        end
        else if (fin_vld)
        begin
            skid_next     = fin;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid              = out_vld_reg;
    assign result.temperature_tenths = out_reg.temperature_tenths;
    assign result.humidity_tenths    = out_reg.humidity_tenths;
    assign result.temp_cal_error     = out_reg.temp_cal_error;
    assign result.hum_cal_error      = out_reg.hum_cal_error;

`ifndef SYNTHESIS
    // a held skid entry always sits behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register empty");

    // a calibration error always reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.temp_cal_error) |-> (result.temperature_tenths == '0))
        else $error("temperature error with nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.hum_cal_error) |-> (result.humidity_tenths == '0))
        else $error("humidity error with nonzero value");

    // humidity never exceeds the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.humidity_tenths <= HUM_CLAMP))
        else $error("humidity above clamp");
`endif

endmodule

`default_nettype wire
